FILE: rtl/tlge_pkg.sv
// ----------------------------------------------------------------------------
// Toroidal life engine package
// Shared widths, operation codes and rule constants for the life engine.
// ----------------------------------------------------------------------------
package tlge_pkg;

  // Field widths of the stream payloads and the side register.
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int SIDE_W  = 7;
  localparam int GEN_W   = 32;
  localparam int CNT_W   = 4;

  localparam int MAX_SIDE_DEF = 64;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Operation codes carried in the input beat.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // B3/S23: birth on three neighbors, survival on two or three.
  localparam logic [CNT_W-1:0] NB_BIRTH = 4'd3;
  localparam logic [CNT_W-1:0] NB_KEEP  = 4'd2;

endpackage

FILE: rtl/tlge_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with a registered read that updates on re.
// ----------------------------------------------------------------------------
module tlge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tlge_row_update.sv
// ----------------------------------------------------------------------------
// Life row update
// Applies the B3/S23 rule to every cell of one row, given the rows above
// and below, with the columns wrapping at the current side.
// ----------------------------------------------------------------------------
module tlge_row_update #(
  parameter int MAX_SIDE = tlge_pkg::MAX_SIDE_DEF
) (
  input  logic [MAX_SIDE-1:0]         row_up,
  input  logic [MAX_SIDE-1:0]         row_mid,
  input  logic [MAX_SIDE-1:0]         row_dn,
  input  logic [$clog2(MAX_SIDE)-1:0] last_col,
  output logic [MAX_SIDE-1:0]         row_new
);

  localparam int AW = $clog2(MAX_SIDE);

  // Cells at the wrap point are the left neighbors of column 0, picked once here.
  logic up_last, mid_last, dn_last;

  assign up_last  = row_up[last_col];
  assign mid_last = row_mid[last_col];
  assign dn_last  = row_dn[last_col];

  for (genvar c = 0; c < MAX_SIDE; c++) begin : g_col
    localparam logic [AW-1:0] COL = AW'(c);
    logic                      up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [tlge_pkg::CNT_W-1:0] cnt;

    if (c == 0) begin : g_left_wrap
      assign up_l  = up_last;
      assign mid_l = mid_last;
      assign dn_l  = dn_last;
    end else begin : g_left
      assign up_l  = row_up[c-1];
      assign mid_l = row_mid[c-1];
      assign dn_l  = row_dn[c-1];
    end

    if (c == MAX_SIDE - 1) begin : g_right_wrap
      assign up_r  = row_up[0];
      assign mid_r = row_mid[0];
      assign dn_r  = row_dn[0];
    end else begin : g_right
      logic at_last;
      assign at_last = (COL == last_col);
      assign up_r  = at_last ? row_up[0]  : row_up[c+1];
      assign mid_r = at_last ? row_mid[0] : row_mid[c+1];
      assign dn_r  = at_last ? row_dn[0]  : row_dn[c+1];
    end

    assign cnt = tlge_pkg::CNT_W'(up_l) + tlge_pkg::CNT_W'(row_up[c]) +
                 tlge_pkg::CNT_W'(up_r) + tlge_pkg::CNT_W'(mid_l) +
                 tlge_pkg::CNT_W'(mid_r) + tlge_pkg::CNT_W'(dn_l) +
                 tlge_pkg::CNT_W'(row_dn[c]) + tlge_pkg::CNT_W'(dn_r);

    // Columns beyond the current side keep their old value.
    assign row_new[c] = (COL > last_col) ? row_mid[c] :
                        ((cnt == tlge_pkg::NB_BIRTH) ||
                         (row_mid[c] && (cnt == tlge_pkg::NB_KEEP)));
  end

endmodule

FILE: rtl/toroidal_life_generation_engine.sv
// ----------------------------------------------------------------------------
// Toroidal life generation engine
// B3/S23 cellular automaton on a square torus held in a row-wide RAM.
// ----------------------------------------------------------------------------
// Usage. Each input beat on in_* carries an operation: write a cell, read a
// cell, or advance the whole grid one generation. Every input beat yields
// exactly one output beat on out_* with the cell value at the addressed
// row and column after the operation and the running generation count.
// The side register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the engine is idle, which the block leaves
// unchecked. A side of zero acts as one, a side above MAX_SIDE as MAX_SIDE.
// Timing. A read or write passes a RAM read state, then a modify and
// write-back state that raises the result beat; in_tready returns in that
// same cycle, so a new beat is taken only once the last result is raised.
// An advance reads the last row and row 0 to prime the row window, sweeps
// the rows through the row update unit, then does the final cell fetch.
// The single RAM port pair, one row per cycle, sets the advance time.
// Reset. A synchronous active-low reset clears the generation count, sets
// side to 64 and starts a clearing pass that writes MAX_SIDE zero rows, one
// per cycle; in_tready stays low until the clearing pass is done.
// Back-pressure. One result is held in the output register; the next beat
// may be accepted while it waits, but that item holds its final state until
// out_tready frees the register.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine #(
  parameter int MAX_SIDE = tlge_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: side of the grid.
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], row[7:2], col[13:8], value[14], zero[15]
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // cell_res[0], generation[32:1], zero[39:33]
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > tlge_pkg::SIDE_W) ? SW : tlge_pkg::SIDE_W;

  localparam logic [AW-1:0] LAST_ROW_ADDR = AW'(MAX_SIDE - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_FETCH   = 3'd2;
  localparam logic [2:0] ST_CELL    = 3'd3;
  localparam logic [2:0] ST_G_LAST  = 3'd4;
  localparam logic [2:0] ST_G_ROW0  = 3'd5;
  localparam logic [2:0] ST_G_PRIME = 3'd6;
  localparam logic [2:0] ST_G_ROW   = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [tlge_pkg::SIDE_W-1:0]  side_r;
  logic [tlge_pkg::GEN_W-1:0]   gen_r, gen_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;

  logic [tlge_pkg::OP_W-1:0]    op_r;
  logic [tlge_pkg::COORD_W-1:0] row_r, col_r;
  logic                         val_r, inside_r;

  logic [MAX_SIDE-1:0]          prev_r, prev_nxt;
  logic [MAX_SIDE-1:0]          cur_r, cur_nxt;
  logic [MAX_SIDE-1:0]          first_r, first_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_cell_r, out_cell_nxt;
  logic [tlge_pkg::GEN_W-1:0]   out_gen_r, out_gen_nxt;

  // RAM port signals.
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;

  // Decoded input beat.
  logic [tlge_pkg::OP_W-1:0]    in_op;
  logic [tlge_pkg::COORD_W-1:0] in_row, in_col;
  logic                         in_val;

  // Effective side and derived values.
  logic [CW-1:0] side_ext, eff_side;
  logic [AW-1:0] last_idx;
  logic          in_inside;
  logic          in_accept, out_free;
  logic [AW-1:0] row_idx, col_idx;
  logic [AW:0]   cnt_plus2;
  logic [MAX_SIDE-1:0] bit_mask, row_dn, row_new;

  assign in_op  = in_tdata[1:0];
  assign in_row = in_tdata[7:2];
  assign in_col = in_tdata[13:8];
  assign in_val = in_tdata[14];

  assign side_ext = CW'(side_r);
  assign eff_side = (side_ext == '0) ? CW'(1) :
                    (side_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : side_ext;
  assign last_idx = AW'(eff_side - CW'(1));

  assign in_inside = (CW'(in_row) < eff_side) && (CW'(in_col) < eff_side);

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign row_idx   = AW'(row_r);
  assign col_idx   = AW'(col_r);
  assign cnt_plus2 = {1'b0, cnt_r} + (AW+1)'(2);
  assign bit_mask  = {{(MAX_SIDE-1){1'b0}}, 1'b1} << col_idx;

  // Row below the one being updated; the last row wraps to the saved row 0.
  assign row_dn = (cnt_r == last_idx) ? first_r : ram_rdata;

  tlge_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlge_row_update #(
    .MAX_SIDE (MAX_SIDE)
  ) u_rule (
    .row_up   (prev_r),
    .row_mid  (cur_r),
    .row_dn   (row_dn),
    .last_col (last_idx),
    .row_new  (row_new)
  );

  // Sequencer. Rows are swept top to bottom with a three-row window in
  // registers; each row is written back in place, which is safe because the
  // old rows it still needs are already held in prev_r, cur_r and first_r.
  // Reads and writes never target the same row in one cycle.
  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cell_nxt  = out_cell_r;
    out_gen_nxt   = out_gen_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = row_idx;

    case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_ROW_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_op == tlge_pkg::OP_STEP) ? ST_G_LAST : ST_FETCH;
        end
      end
      ST_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_gen_nxt   = gen_r;
          if (op_r == tlge_pkg::OP_WRITE) begin
            out_cell_nxt = inside_r && val_r;
            ram_we       = inside_r;
            ram_waddr    = row_idx;
            ram_wdata    = (ram_rdata & ~bit_mask) | (val_r ? bit_mask : '0);
          end else begin
            out_cell_nxt = inside_r && ram_rdata[col_idx];
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_G_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx;
        state_nxt = ST_G_ROW0;
      end
      ST_G_ROW0: begin
        prev_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_G_PRIME;
      end
      ST_G_PRIME: begin
        cur_nxt   = ram_rdata;
        first_nxt = ram_rdata;
        ram_re    = (last_idx != '0);
        ram_raddr = AW'(1);
        cnt_nxt   = '0;
        state_nxt = ST_G_ROW;
      end
      ST_G_ROW: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = row_new;
        prev_nxt  = cur_r;
        cur_nxt   = row_dn;
        ram_re    = (cnt_plus2 <= {1'b0, last_idx});
        ram_raddr = cnt_plus2[AW-1:0];
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == last_idx) begin
          gen_nxt   = gen_r + tlge_pkg::GEN_W'(1);
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      gen_r       <= '0;
      side_r      <= tlge_pkg::SIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        side_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    first_r    <= first_nxt;
    out_cell_r <= out_cell_nxt;
    out_gen_r  <= out_gen_nxt;
    if (in_accept) begin
      op_r     <= in_op;
      row_r    <= in_row;
      col_r    <= in_col;
      val_r    <= in_val;
      inside_r <= in_inside;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_gen_r, out_cell_r};

  // A result beat only appears after the cell stage has finished an item.
  a_out_from_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CELL))
    else $error("result beat raised outside the cell stage");

  // The sweep never reads a row in the cycle it writes that row.
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid RAM read and write hit the same row");

  // The generation count only ever steps by one.
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(gen_r) |-> (gen_r == $past(gen_r) + tlge_pkg::GEN_W'(1)))
    else $error("generation count jumped");

endmodule
